### hdl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, S-box tables and GF(2^8) helpers for the AES-128 block cipher.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_pkg;

    localparam int unsigned BlockW  = 64;
    localparam int unsigned NumRk   = 11;
    localparam int unsigned RkAddrW = 4;
    localparam int unsigned RkW     = 128;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_OUT
    } state_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
        return t[x];
    endfunction

    function automatic logic [7:0] rcon(input logic [RkAddrW-1:0] n);
        logic [7:0] r;
        case (n)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1B;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    // byte i of the state sits at bits [127-8i -: 8]
    function automatic logic [7:0] gb(input logic [127:0] s, input int unsigned i);
        return s[127 - 8*i -: 8];
    endfunction

endpackage
`default_nettype wire

### hdl/aes_if.sv
// ----------------------------------------------------------------------------
// AES stream interfaces
// Valid/ready channels for blocks, results and configuration words.
// ----------------------------------------------------------------------------
`default_nettype none
interface aes_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [63:0] block_high;
    logic [63:0] block_low;
    modport source (output valid, req_type, block_high, block_low, input ready);
    modport sink   (input valid, req_type, block_high, block_low, output ready);
endinterface

interface aes_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;
    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/aes_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output      logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hdl/aes_round.sv
// ----------------------------------------------------------------------------
// AES round datapath
// One forward or inverse round of the cipher, key addition included.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_round (
    input  wire logic         dec,
    input  wire logic         last,
    input  wire logic [127:0] s,
    input  wire logic [127:0] rk,
    output      logic [127:0] q
);
    logic [127:0] ss;
    logic [127:0] sk;
    logic [127:0] mx;
    logic [7:0]   a0, a1, a2, a3;
    logic [7:0]   x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (dec)
                    ss[127 - 8*(4*c+r) -: 8] =
                        aes_pkg::inv_sbox(aes_pkg::gb(s, 4*((c + 3*r) % 4) + r));
                else
                    ss[127 - 8*(4*c+r) -: 8] =
                        aes_pkg::sbox(aes_pkg::gb(s, 4*((c + r) % 4) + r));
            end
        end
        // decrypt adds the key before the inverse column mix
        sk = dec ? (ss ^ rk) : ss;
        for (int c = 0; c < 4; c++)
        begin
            a0 = aes_pkg::gb(sk, 4*c);
            a1 = aes_pkg::gb(sk, 4*c+1);
            a2 = aes_pkg::gb(sk, 4*c+2);
            a3 = aes_pkg::gb(sk, 4*c+3);
            x0 = aes_pkg::xt(a0); x1 = aes_pkg::xt(a1);
            x2 = aes_pkg::xt(a2); x3 = aes_pkg::xt(a3);
            y0 = aes_pkg::xt(x0); y1 = aes_pkg::xt(x1);
            y2 = aes_pkg::xt(x2); y3 = aes_pkg::xt(x3);
            z0 = aes_pkg::xt(y0); z1 = aes_pkg::xt(y1);
            z2 = aes_pkg::xt(y2); z3 = aes_pkg::xt(y3);
            if (dec)
            begin
                // 0e,0b,0d,09
                mx[127-32*c -: 8] = (z0^y0^x0) ^ (z1^x1^a1) ^ (z2^y2^a2) ^ (z3^a3);
                mx[119-32*c -: 8] = (z1^y1^x1) ^ (z2^x2^a2) ^ (z3^y3^a3) ^ (z0^a0);
                mx[111-32*c -: 8] = (z2^y2^x2) ^ (z3^x3^a3) ^ (z0^y0^a0) ^ (z1^a1);
                mx[103-32*c -: 8] = (z3^y3^x3) ^ (z0^x0^a0) ^ (z1^y1^a1) ^ (z2^a2);
            end
            else
            begin
                mx[127-32*c -: 8] = x0 ^ (x1^a1) ^ a2 ^ a3;
                mx[119-32*c -: 8] = x1 ^ (x2^a2) ^ a3 ^ a0;
                mx[111-32*c -: 8] = x2 ^ (x3^a3) ^ a0 ^ a1;
                mx[103-32*c -: 8] = x3 ^ (x0^a0) ^ a1 ^ a2;
            end
        end
        if (dec)
            q = last ? sk : mx;
        else
            q = last ? (ss ^ rk) : (mx ^ rk);
    end
endmodule
`default_nettype wire

### hdl/aes128_block_cipher.sv
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Iterative AES-128 encrypt/decrypt; round keys held in a synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  req     | in  | req_type, block_high, block_low
//  rsp     | out | result_high, result_low
//  cfg     | in  | index (0 key_high, 1 key_low), data
//
//  A block is accepted in idle and its result reaches the output register
//  after the load with initial key addition, ten rounds of the shared round
//  unit and the handoff; idle follows, and only then is the next block taken.
//  After a key write the next block first expands the schedule into the
//  round-key RAM (one key per cycle) before its load.
//  Reset clears the key to zero and marks the schedule stale.
//  A block is taken while the previous result waits in the output register;
//  its handoff then stalls until that result is taken.
`default_nettype none
module aes128_block_cipher (
    input wire logic    clk,
    input wire logic    rst_n,
    aes_req_if.sink     req,
    aes_rsp_if.source   rsp,
    aes_cfg_if.sink     cfg
);
    aes_pkg::state_t state_reg, state_next;

    logic [63:0]  key_high_reg, key_low_reg;
    logic         key_ok_reg, key_ok_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic [127:0] kexp_reg, kexp_next;
    logic [127:0] st_reg, st_next;
    logic         dec_reg, dec_next;
    logic         ov_reg, ov_next;
    logic [127:0] out_reg, out_next;
    logic         fwd_reg, fwd_next;
    logic [127:0] fwd_key_reg, fwd_key_next;

    logic         we;
    logic [3:0]   waddr, raddr;
    logic [127:0] wdata, rk, rk_ram;
    logic [127:0] rq;
    logic [31:0]  w0, w1, w2, w3, tw;
    logic         accept, last;

    aes_ram #(.Width(aes_pkg::RkW), .Depth(16)) u_rk (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rk_ram)
    );

    // read of the entry written in the same cycle takes the written key
    assign fwd_next     = we && (waddr == raddr);
    assign fwd_key_next = wdata;
    assign rk           = fwd_reg ? fwd_key_reg : rk_ram;

    aes_round u_round (
        .dec(dec_reg), .last(last), .s(st_reg), .rk(rk), .q(rq)
    );

    assign cfg.ready = (state_reg == aes_pkg::ST_IDLE);
    assign req.ready = (state_reg == aes_pkg::ST_IDLE) && !cfg.valid;
    assign accept    = req.valid && req.ready;
    assign rsp.valid = ov_reg;
    assign rsp.result_high = out_reg[127:64];
    assign rsp.result_low  = out_reg[63:0];
    assign last = (cnt_reg == 4'd10);

    // key expansion step
    always_comb
    begin
        tw = {aes_pkg::sbox(kexp_reg[23:16]) ^ aes_pkg::rcon(cnt_reg + 4'd1),
              aes_pkg::sbox(kexp_reg[15:8]), aes_pkg::sbox(kexp_reg[7:0]),
              aes_pkg::sbox(kexp_reg[31:24])};
        w0 = kexp_reg[127:96] ^ tw;
        w1 = kexp_reg[95:64] ^ w0;
        w2 = kexp_reg[63:32] ^ w1;
        w3 = kexp_reg[31:0] ^ w2;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aes_pkg::ST_IDLE:
                if (accept)
                    state_next = key_ok_reg ? aes_pkg::ST_LOAD : aes_pkg::ST_EXPAND;
            aes_pkg::ST_EXPAND:
                if (cnt_reg == 4'd10)
                    state_next = aes_pkg::ST_LOAD;
            aes_pkg::ST_LOAD:
                state_next = aes_pkg::ST_ROUND;
            aes_pkg::ST_ROUND:
                if (last)
                    state_next = aes_pkg::ST_OUT;
            aes_pkg::ST_OUT:
                if (!ov_reg || rsp.ready)
                    state_next = aes_pkg::ST_IDLE;
            default:
                state_next = aes_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        key_ok_next = key_ok_reg;
        cnt_next    = cnt_reg;
        kexp_next   = kexp_reg;
        st_next     = st_reg;
        dec_next    = dec_reg;
        ov_next     = ov_reg && !rsp.ready;
        out_next    = out_reg;
        we          = 1'b0;
        waddr       = cnt_reg;
        wdata       = kexp_reg;
        raddr       = 4'd0;
        unique case (state_reg)
            aes_pkg::ST_IDLE:
            begin
                if (cfg.valid)
                    key_ok_next = 1'b0;
                if (accept)
                begin
                    st_next   = {req.block_high, req.block_low};
                    dec_next  = req.req_type;
                    kexp_next = {key_high_reg, key_low_reg};
                    cnt_next  = 4'd0;
                end
                raddr = (req.req_type == aes_pkg::OP_DECRYPT) ? 4'd10 : 4'd0;
            end
            aes_pkg::ST_EXPAND:
            begin
                we = 1'b1;
                if (cnt_reg != 4'd10)
                begin
                    kexp_next = {w0, w1, w2, w3};
                    cnt_next  = cnt_reg + 4'd1;
                end
                else
                begin
                    key_ok_next = 1'b1;
                    cnt_next    = 4'd0;
                end
                raddr = dec_reg ? 4'd10 : 4'd0;
            end
            aes_pkg::ST_LOAD:
            begin
                st_next  = st_reg ^ rk;
                cnt_next = 4'd1;
                raddr    = dec_reg ? 4'd9 : 4'd1;
            end
            aes_pkg::ST_ROUND:
            begin
                st_next  = rq;
                cnt_next = last ? 4'd0 : (cnt_reg + 4'd1);
                raddr    = dec_reg ? (4'd9 - cnt_reg) : (cnt_reg + 4'd1);
            end
            aes_pkg::ST_OUT:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next  = 1'b1;
                    out_next = st_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= aes_pkg::ST_IDLE;
            key_high_reg <= '0;
            key_low_reg  <= '0;
            key_ok_reg   <= 1'b0;
            ov_reg       <= 1'b0;
            cnt_reg      <= '0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            key_ok_reg <= key_ok_next;
            ov_reg     <= ov_next;
            cnt_reg    <= cnt_next;
            fwd_reg    <= fwd_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == aes_pkg::CFG_KEY_HIGH)
                    key_high_reg <= cfg.data;
                else
                    key_low_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kexp_reg    <= kexp_next;
        st_reg      <= st_next;
        dec_reg     <= dec_next;
        out_reg     <= out_next;
        fwd_key_reg <= fwd_key_next;
    end

`ifndef SYNTHESIS
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'd10)
        else $error("round counter out of range");
    a_stale_key: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aes_pkg::ST_LOAD) |-> key_ok_reg)
        else $error("rounds started on stale schedule");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !rsp.ready) |=> $stable(out_reg))
        else $error("pending result overwritten");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready) |-> !accept)
        else $error("key write with block accept");
`endif
endmodule
`default_nettype wire

### bench/aes128_block_cipher_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 result checker
// Watches the key, block and result channels, computes each expected block
// with its own AES-128 and compares results in order.
// ----------------------------------------------------------------------------
module aes128_block_cipher_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic        req_type,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [63:0] result_high,
    input  logic [63:0] result_low,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    logic [7:0] fwd_tab [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};

    logic [7:0] rev_tab [256];
    logic [7:0] rnd_const [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                   8'h20, 8'h40, 8'h80, 8'h1B, 8'h36};

    logic [63:0]  key_hi, key_lo;
    logic [127:0] expected_blocks [$];

    initial begin
        for (int i = 0; i < 256; i++)
            rev_tab[fwd_tab[i]] = i[7:0];
    end

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i])
                acc ^= a;
            a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1B) : {a[6:0], 1'b0};
        end
        return acc;
    endfunction

    // state byte i is row i%4 of column i/4; byte 0 in the top bits
    function automatic logic [127:0] aes_cipher(input logic decrypt, input logic [127:0] blk,
                                                input logic [127:0] key);
        logic [7:0] rk [176];
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] w [4];
        logic [7:0] f;
        int r;
        int dir;
        for (int i = 0; i < 16; i++) begin
            rk[i] = key[127 - 8*i -: 8];
            s[i]  = blk[127 - 8*i -: 8];
        end
        for (int n = 16; n < 176; n += 4) begin
            for (int k = 0; k < 4; k++)
                w[k] = rk[n - 4 + k];
            if (n % 16 == 0) begin
                f = w[0];
                w[0] = fwd_tab[w[1]] ^ rnd_const[n/16 - 1];
                w[1] = fwd_tab[w[2]];
                w[2] = fwd_tab[w[3]];
                w[3] = fwd_tab[f];
            end
            for (int k = 0; k < 4; k++)
                rk[n + k] = rk[n - 16 + k] ^ w[k];
        end
        dir = decrypt ? 3 : 1;
        for (int i = 0; i < 16; i++)
            s[i] ^= rk[decrypt ? 160 + i : i];
        for (int step = 1; step <= 10; step++) begin
            r = decrypt ? 10 - step : step;
            for (int c = 0; c < 4; c++)
                for (int q = 0; q < 4; q++)
                    t[4*c + q] = decrypt ? rev_tab[s[4*((c + dir*q) % 4) + q]]
                                         : fwd_tab[s[4*((c + dir*q) % 4) + q]];
            s = t;
            if (decrypt)
                for (int i = 0; i < 16; i++)
                    s[i] ^= rk[16*r + i];
            if (step < 10) begin
                for (int c = 0; c < 4; c++)
                    for (int q = 0; q < 4; q++)
                        t[4*c + q] = decrypt
                            ? gmul(s[4*c + q], 8'h0E) ^ gmul(s[4*c + (q+1)%4], 8'h0B)
                              ^ gmul(s[4*c + (q+2)%4], 8'h0D) ^ gmul(s[4*c + (q+3)%4], 8'h09)
                            : gmul(s[4*c + q], 8'h02) ^ gmul(s[4*c + (q+1)%4], 8'h03)
                              ^ s[4*c + (q+2)%4] ^ s[4*c + (q+3)%4];
                s = t;
            end
            if (!decrypt)
                for (int i = 0; i < 16; i++)
                    s[i] ^= rk[16*r + i];
        end
        for (int i = 0; i < 16; i++)
            aes_cipher[127 - 8*i -: 8] = s[i];
    endfunction

    assign pending = expected_blocks.size();

    always @(posedge clk or negedge rst_n) begin
        logic [127:0] want;
        int errs;
        errs = 0;
        if (!rst_n) begin
            key_hi     <= '0;
            key_lo     <= '0;
            fail_count <= 0;
            expected_blocks.delete();
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == aes_pkg::CFG_KEY_HIGH)
                    key_hi <= cfg_data;
                else
                    key_lo <= cfg_data;
            end
            if (req_valid && req_ready)
                expected_blocks.push_back(aes_cipher(req_type == aes_pkg::OP_DECRYPT,
                                                     {block_high, block_low},
                                                     {key_hi, key_lo}));
            if (rsp_valid && rsp_ready) begin
                if (expected_blocks.size() == 0) begin
                    $error("unexpected result word %h %h", result_high, result_low);
                    errs++;
                end
                else begin
                    want = expected_blocks.pop_front();
                    if (result_high !== want[127:64]) begin
                        $error("result_high expected %h actual %h", want[127:64], result_high);
                        errs++;
                    end
                    if (result_low !== want[63:0]) begin
                        $error("result_low expected %h actual %h", want[63:0], result_low);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end

endmodule

### bench/aes128_block_cipher_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Drives key writes and blocks with random gaps and output stalls across
// several keys; the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module aes128_block_cipher_test;

    localparam int NumRandom  = 1800;
    localparam int CycleLimit = 1000000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycles;

    aes_req_if req ();
    aes_rsp_if rsp ();
    aes_cfg_if cfg ();

    aes128_block_cipher dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg));

    aes128_block_cipher_check checker_inst (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req.valid), .req_ready(req.ready), .req_type(req.req_type),
        .block_high(req.block_high), .block_low(req.block_low),
        .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
        .result_high(rsp.result_high), .result_low(rsp.result_low),
        .cfg_valid(cfg.valid), .cfg_ready(cfg.ready), .cfg_index(cfg.index),
        .cfg_data(cfg.data), .fail_count(fail_count), .pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("aes128_block_cipher verification failed");
                $finish;
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output stalls
    initial begin
        int n;
        rsp.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (cycles > 3000 && cycles < 5000) begin
                rsp.ready <= 1'b1;
            end
            else begin
                n = gap_len();
                if (n > 0) begin
                    rsp.ready <= 1'b0;
                    repeat (n - 1) @(negedge clk);
                    @(negedge clk);
                end
                rsp.ready <= 1'b1;
            end
        end
    end

    task automatic write_key(input logic idx, input logic [63:0] value);
        cfg.index = idx;
        cfg.data  = value;
        cfg.valid = 1'b1;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
        int n;
        n = gap_len();
        repeat (n) @(negedge clk);
        req.req_type   = op;
        req.block_high = hi;
        req.block_low  = lo;
        req.valid      = 1'b1;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            2:       v = 64'h1 << $urandom_range(0, 63);
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    initial begin
        logic [63:0] nist_pt_hi, nist_pt_lo;
        req.valid = 1'b0;
        req.req_type = aes_pkg::OP_ENCRYPT;
        req.block_high = '0;
        req.block_low = '0;
        cfg.valid = 1'b0;
        cfg.index = aes_pkg::CFG_KEY_HIGH;
        cfg.data = '0;
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // key never written: all-zero key
        send_block(aes_pkg::OP_ENCRYPT, '0, '0);
        send_block(aes_pkg::OP_DECRYPT, '0, '0);
        send_block(aes_pkg::OP_ENCRYPT, '1, '1);
        send_block(aes_pkg::OP_DECRYPT, '1, '1);
        drain();

        // standard test key and block
        write_key(aes_pkg::CFG_KEY_HIGH, 64'h0001020304050607);
        write_key(aes_pkg::CFG_KEY_LOW,  64'h08090a0b0c0d0e0f);
        nist_pt_hi = 64'h0011223344556677;
        nist_pt_lo = 64'h8899aabbccddeeff;
        send_block(aes_pkg::OP_ENCRYPT, nist_pt_hi, nist_pt_lo);
        send_block(aes_pkg::OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block(aes_pkg::OP_ENCRYPT, 64'h8000000000000000, 64'h0);
        send_block(aes_pkg::OP_DECRYPT, 64'h0, 64'h1);
        drain();

        // all-ones key
        write_key(aes_pkg::CFG_KEY_HIGH, '1);
        write_key(aes_pkg::CFG_KEY_LOW, '1);
        for (int i = 0; i < 4; i++)
            send_block(i[0] ? aes_pkg::OP_DECRYPT : aes_pkg::OP_ENCRYPT,
                       i[1] ? '1 : '0, i[1] ? '0 : '1);
        drain();

        // only one half changed
        write_key(aes_pkg::CFG_KEY_LOW, '0);
        send_block(aes_pkg::OP_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(aes_pkg::OP_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
        drain();

        for (int i = 0; i < NumRandom; i++) begin
            if (i % 150 == 0) begin
                drain();
                if ($urandom_range(0, 2) != 0)
                    write_key(aes_pkg::CFG_KEY_HIGH, rand64());
                if ($urandom_range(0, 2) != 0)
                    write_key(aes_pkg::CFG_KEY_LOW, rand64());
            end
            send_block(1'($urandom_range(0, 1)), rand64(), rand64());
        end

        drain();
        if (fail_count == 0)
            $display("aes128_block_cipher verification clean");
        else
            $display("aes128_block_cipher verification failed");
        $finish;
    end

endmodule
